// ===== rtl/cmfe_pkg.sv =====
`default_nettype none

package cmfe_pkg;

   // Request modes
   typedef enum logic [2:0] {
      MODE_SDO_WRITE = 3'd0,
      MODE_SDO_READ  = 3'd1,
      MODE_RX_FRAME  = 3'd2,
      MODE_TICK      = 3'd3,
      MODE_NMT       = 3'd4,
      MODE_SYNC      = 3'd5
   } mode_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_REJECT     = 3'd0,
      KIND_TRANSMIT   = 3'd1,
      KIND_HEARTBEAT  = 3'd2,
      KIND_EMCY       = 3'd3,
      KIND_PDO        = 3'd4,
      KIND_READ_DONE  = 3'd5,
      KIND_WRITE_DONE = 3'd6
   } kind_type;

   // Reported NMT states
   typedef enum logic [2:0] {
      NMT_UNKNOWN     = 3'd0,
      NMT_BOOT_UP     = 3'd1,
      NMT_STOPPED     = 3'd2,
      NMT_OPERATIONAL = 3'd3,
      NMT_PRE_OP      = 3'd4
   } nmt_state_type;

   // Function codes: identifier bits 10:7
   localparam logic [3:0] FC_EMCY      = 4'h1;
   localparam logic [3:0] FC_TPDO1     = 4'h3;
   localparam logic [3:0] FC_RPDO1     = 4'h4;
   localparam logic [3:0] FC_TPDO2     = 4'h5;
   localparam logic [3:0] FC_RPDO2     = 4'h6;
   localparam logic [3:0] FC_TPDO3     = 4'h7;
   localparam logic [3:0] FC_RPDO3     = 4'h8;
   localparam logic [3:0] FC_TPDO4     = 4'h9;
   localparam logic [3:0] FC_RPDO4     = 4'hA;
   localparam logic [3:0] FC_SDO_RESP  = 4'hB;
   localparam logic [3:0] FC_HEARTBEAT = 4'hE;

   // Identifiers
   localparam logic [10:0] ID_NMT      = 11'h000;
   localparam logic [10:0] ID_SYNC     = 11'h080;
   localparam logic [10:0] ID_SDO_REQ  = 11'h600;

   // SDO command bytes
   localparam logic [7:0] SDO_CMD_DOWNLOAD = 8'h23;
   localparam logic [7:0] SDO_CMD_UPLOAD   = 8'h40;
   localparam logic [7:0] SDO_SCS_ABORT    = 8'h80;
   localparam logic [7:0] SDO_SCS_DL_ACK   = 8'h60;
   localparam logic [7:0] SDO_SCS_MASK     = 8'hE0;
   localparam logic [7:0] SDO_SCS_UPLOAD   = 8'h40;
   localparam logic [31:0] SDO_ABORT_TIMEOUT = 32'h0504_0000;

   // Heartbeat state bytes
   localparam logic [6:0] HB_BOOT_UP     = 7'h00;
   localparam logic [6:0] HB_STOPPED     = 7'h04;
   localparam logic [6:0] HB_OPERATIONAL = 7'h05;
   localparam logic [6:0] HB_PRE_OP      = 7'h7F;

   // Register map
   localparam logic RegNodeId  = 1'b0;
   localparam logic RegTimeout = 1'b1;

   // Reset values
   localparam logic [6:0]  NODE_ID_RESET = 7'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] obj_index;
      logic [7:0]  obj_subindex;
      logic [31:0] write_value;
      logic [2:0]  write_size;
      logic [7:0]  nmt_command;
      logic [6:0]  target_node;
      logic [10:0] frame_id;
      logic        frame_extended;
      logic [3:0]  frame_len;
      logic [63:0] frame_data;
   } req_type;

   typedef struct packed {
      kind_type      kind;
      logic [10:0]   tx_id;
      logic [63:0]   payload;
      logic [3:0]    payload_len;
      logic [6:0]    node;
      nmt_state_type nmt_state;
      logic [2:0]    pdo_number;
      logic          pdo_is_transmit;
      logic          success;
      logic [15:0]   result_index;
      logic [7:0]    result_subindex;
      logic [31:0]   result_value;
   } rsp_type;

   // Keep the bytes below len (len of 8 or more keeps all)
   function automatic logic [63:0] keep_bytes(input logic [63:0] data,
                                              input logic [3:0] len);
      logic [63:0] res;
      res = '0;
      for (int i = 0; i < 8; i++) begin
         if (4'(i) < len) begin
            res[8*i +: 8] = data[8*i +: 8];
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/canopen_master_frame_engine.sv =====
`default_nettype none

// A request goes through the request register, then the result register, which drives rsp_valid.
// One request per cycle unless a result stalls; requests with no result still take one slot.
// A waiting result does not block the request register, so one more request is taken.
// Reset (synchronous, active high): no transfer pending, node_id 1, timeout 1000 ticks.
module canopen_master_frame_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_mode,
   input  wire logic [15:0] req_obj_index,
   input  wire logic [7:0]  req_obj_subindex,
   input  wire logic [31:0] req_write_value,
   input  wire logic [2:0]  req_write_size,
   input  wire logic [7:0]  req_nmt_command,
   input  wire logic [6:0]  req_target_node,
   input  wire logic [10:0] req_frame_id,
   input  wire logic        req_frame_extended,
   input  wire logic [3:0]  req_frame_len,
   input  wire logic [63:0] req_frame_data,
   // result channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_kind,
   output logic [10:0]      rsp_tx_id,
   output logic [63:0]      rsp_payload,
   output logic [3:0]       rsp_payload_len,
   output logic [6:0]       rsp_node,
   output logic [2:0]       rsp_nmt_state,
   output logic [2:0]       rsp_pdo_number,
   output logic             rsp_pdo_is_transmit,
   output logic             rsp_success,
   output logic [15:0]      rsp_result_index,
   output logic [7:0]       rsp_result_subindex,
   output logic [31:0]      rsp_result_value,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   // Configuration registers
   logic [6:0]  node_id_ff;
   logic [15:0] timeout_ff;
   logic        csr_wr;

   // Request register
   logic              req_valid_ff;
   cmfe_pkg::req_type req_ff;

   // Result register
   logic              rsp_valid_ff;
   cmfe_pkg::rsp_type rsp_ff;

   // SDO transfer state
   logic        sdo_pending_ff, sdo_pending_in;
   logic        pending_is_read_ff, pending_is_read_in;
   logic [15:0] pending_index_ff, pending_index_in;
   logic [7:0]  pending_subindex_ff, pending_subindex_in;
   logic [15:0] ticks_left_ff, ticks_left_in;

   logic              advance;
   logic              res_valid;
   cmfe_pkg::rsp_type res;

   // Decode helpers
   logic [3:0]  rx_len;
   logic [63:0] rx_data;
   logic [3:0]  rx_fc;
   logic [6:0]  rx_node;
   logic [7:0]  scs;
   logic [2:0]  up_size;
   logic [31:0] up_value;
   logic [7:0]  dl_cmd;
   logic [31:0] dl_data;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_id_ff <= cmfe_pkg::NODE_ID_RESET;
         timeout_ff <= cmfe_pkg::TIMEOUT_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == cmfe_pkg::RegNodeId) begin
            node_id_ff <= csr_pwdata[6:0];
         end else begin
            timeout_ff <= csr_pwdata[15:0];
         end
      end
   end

   always_comb begin
      if (csr_paddr[2] == cmfe_pkg::RegTimeout) begin
         csr_prdata = {16'd0, timeout_ff};
      end else begin
         csr_prdata = {25'd0, node_id_ff};
      end
   end

   // Handshake: the request register moves on whenever the result slot frees up
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff.mode           <= req_mode;
         req_ff.obj_index      <= req_obj_index;
         req_ff.obj_subindex   <= req_obj_subindex;
         req_ff.write_value    <= req_write_value;
         req_ff.write_size     <= req_write_size;
         req_ff.nmt_command    <= req_nmt_command;
         req_ff.target_node    <= req_target_node;
         req_ff.frame_id       <= req_frame_id;
         req_ff.frame_extended <= req_frame_extended;
         req_ff.frame_len      <= req_frame_len;
         req_ff.frame_data     <= req_frame_data;
      end
   end

   // Frame field extraction
   always_comb begin
      rx_len  = (req_ff.frame_len > 4'd8) ? 4'd8 : req_ff.frame_len;
      rx_data = cmfe_pkg::keep_bytes(req_ff.frame_data, rx_len);
      rx_fc   = req_ff.frame_id[10:7];
      rx_node = req_ff.frame_id[6:0];
      scs     = rx_data[7:0];
      // expedited upload with size indicated: 4 - n bytes
      if (scs[1] && scs[0]) begin
         up_size = 3'd4 - {1'b0, scs[3:2]};
      end else begin
         up_size = 3'd4;
      end
      up_value = '0;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < up_size) begin
            up_value[8*i +: 8] = rx_data[32 + 8*i +: 8];
         end
      end
      // download command and masked data
      dl_cmd  = cmfe_pkg::SDO_CMD_DOWNLOAD |
                {4'd0, 2'(3'd4 - req_ff.write_size), 2'd0};
      dl_data = 32'(cmfe_pkg::keep_bytes({32'd0, req_ff.write_value},
                                         {1'b0, req_ff.write_size}));
   end

   // Per-request processing and state update
   always_comb begin
      res_valid           = 1'b0;
      res                 = '0;
      sdo_pending_in      = sdo_pending_ff;
      pending_is_read_in  = pending_is_read_ff;
      pending_index_in    = pending_index_ff;
      pending_subindex_in = pending_subindex_ff;
      ticks_left_in       = ticks_left_ff;

      // fields shared by every SDO completion
      res.result_index    = pending_index_ff;
      res.result_subindex = pending_subindex_ff;

      if (req_valid_ff) begin
         case (req_ff.mode)
            cmfe_pkg::MODE_SDO_WRITE,
            cmfe_pkg::MODE_SDO_READ: begin
               res_valid = 1'b1;
               res       = '0;
               if (sdo_pending_ff ||
                   (req_ff.mode == cmfe_pkg::MODE_SDO_WRITE &&
                    (req_ff.write_size < 3'd1 || req_ff.write_size > 3'd4))) begin
                  res.kind = cmfe_pkg::KIND_REJECT;
               end else begin
                  res.kind        = cmfe_pkg::KIND_TRANSMIT;
                  res.tx_id       = cmfe_pkg::ID_SDO_REQ + {4'd0, node_id_ff};
                  res.payload_len = 4'd8;
                  if (req_ff.mode == cmfe_pkg::MODE_SDO_READ) begin
                     res.payload = {32'd0, req_ff.obj_subindex, req_ff.obj_index,
                                    cmfe_pkg::SDO_CMD_UPLOAD};
                  end else begin
                     res.payload = {dl_data, req_ff.obj_subindex, req_ff.obj_index,
                                    dl_cmd};
                  end
                  sdo_pending_in      = 1'b1;
                  pending_is_read_in  = (req_ff.mode == cmfe_pkg::MODE_SDO_READ);
                  pending_index_in    = req_ff.obj_index;
                  pending_subindex_in = req_ff.obj_subindex;
                  ticks_left_in       = timeout_ff;
               end
            end

            cmfe_pkg::MODE_RX_FRAME: begin
               if (!req_ff.frame_extended) begin
                  case (rx_fc)
                     cmfe_pkg::FC_HEARTBEAT: begin
                        if (rx_node != 7'd0) begin
                           res_valid = 1'b1;
                           res       = '0;
                           res.kind  = cmfe_pkg::KIND_HEARTBEAT;
                           res.node  = rx_node;
                           if (rx_len != 4'd0) begin
                              case (rx_data[6:0])
                                 cmfe_pkg::HB_BOOT_UP:     res.nmt_state = cmfe_pkg::NMT_BOOT_UP;
                                 cmfe_pkg::HB_STOPPED:     res.nmt_state = cmfe_pkg::NMT_STOPPED;
                                 cmfe_pkg::HB_OPERATIONAL: res.nmt_state = cmfe_pkg::NMT_OPERATIONAL;
                                 cmfe_pkg::HB_PRE_OP:      res.nmt_state = cmfe_pkg::NMT_PRE_OP;
                                 default:                  res.nmt_state = cmfe_pkg::NMT_UNKNOWN;
                              endcase
                           end
                        end
                     end

                     cmfe_pkg::FC_EMCY: begin
                        if (rx_node != 7'd0 && rx_len >= 4'd3) begin
                           res_valid        = 1'b1;
                           res              = '0;
                           res.kind         = cmfe_pkg::KIND_EMCY;
                           res.node         = rx_node;
                           res.result_value = {8'd0, rx_data[23:0]};
                           res.payload      = {24'd0, rx_data[63:24]};
                           res.payload_len  = rx_len - 4'd3;
                        end
                     end

                     cmfe_pkg::FC_SDO_RESP: begin
                        // only answers from our server, while a transfer is open
                        if (rx_node == node_id_ff && sdo_pending_ff && rx_len != 4'd0) begin
                           res_valid      = 1'b1;
                           sdo_pending_in = 1'b0;
                           ticks_left_in  = 16'd0;
                           res.kind       = pending_is_read_ff ? cmfe_pkg::KIND_READ_DONE
                                                               : cmfe_pkg::KIND_WRITE_DONE;
                           if (scs == cmfe_pkg::SDO_SCS_ABORT) begin
                              res.success      = 1'b0;
                              res.result_value = (rx_len >= 4'd8) ? rx_data[63:32] : 32'd0;
                           end else if (!pending_is_read_ff) begin
                              res.success = (scs == cmfe_pkg::SDO_SCS_DL_ACK);
                           end else if ((scs & cmfe_pkg::SDO_SCS_MASK) !=
                                        cmfe_pkg::SDO_SCS_UPLOAD) begin
                              res.success = 1'b0;
                           end else begin
                              res.success      = 1'b1;
                              res.result_value = up_value;
                           end
                        end
                     end

                     cmfe_pkg::FC_TPDO1, cmfe_pkg::FC_RPDO1,
                     cmfe_pkg::FC_TPDO2, cmfe_pkg::FC_RPDO2,
                     cmfe_pkg::FC_TPDO3, cmfe_pkg::FC_RPDO3,
                     cmfe_pkg::FC_TPDO4, cmfe_pkg::FC_RPDO4: begin
                        if (rx_node != 7'd0) begin
                           res_valid           = 1'b1;
                           res                 = '0;
                           res.kind            = cmfe_pkg::KIND_PDO;
                           res.node            = rx_node;
                           // codes 3..10 map pairwise onto PDO 1..4, odd is transmit
                           res.pdo_number      = 3'((rx_fc - 4'd1) >> 1);
                           res.pdo_is_transmit = rx_fc[0];
                           res.payload         = rx_data;
                           res.payload_len     = rx_len;
                        end
                     end

                     default: begin
                        res_valid = 1'b0;
                     end
                  endcase
               end
            end

            cmfe_pkg::MODE_TICK: begin
               if (sdo_pending_ff) begin
                  if (ticks_left_ff > 16'd1) begin
                     ticks_left_in = ticks_left_ff - 16'd1;
                  end else begin
                     res_valid        = 1'b1;
                     ticks_left_in    = 16'd0;
                     sdo_pending_in   = 1'b0;
                     res.kind         = pending_is_read_ff ? cmfe_pkg::KIND_READ_DONE
                                                           : cmfe_pkg::KIND_WRITE_DONE;
                     res.success      = 1'b0;
                     res.result_value = cmfe_pkg::SDO_ABORT_TIMEOUT;
                  end
               end
            end

            cmfe_pkg::MODE_NMT: begin
               res_valid       = 1'b1;
               res             = '0;
               res.kind        = cmfe_pkg::KIND_TRANSMIT;
               res.tx_id       = cmfe_pkg::ID_NMT;
               res.payload     = {49'd0, req_ff.target_node, req_ff.nmt_command};
               res.payload_len = 4'd2;
            end

            cmfe_pkg::MODE_SYNC: begin
               res_valid = 1'b1;
               res       = '0;
               res.kind  = cmfe_pkg::KIND_TRANSMIT;
               res.tx_id = cmfe_pkg::ID_SYNC;
            end

            default: begin
               res_valid = 1'b0;
            end
         endcase
      end
   end

   // State registers update once per request, when it leaves the request register
   always_ff @(posedge clock) begin
      if (reset) begin
         sdo_pending_ff      <= 1'b0;
         pending_is_read_ff  <= 1'b0;
         pending_index_ff    <= '0;
         pending_subindex_ff <= '0;
         ticks_left_ff       <= '0;
      end else if (req_valid_ff && advance) begin
         sdo_pending_ff      <= sdo_pending_in;
         pending_is_read_ff  <= pending_is_read_in;
         pending_index_ff    <= pending_index_in;
         pending_subindex_ff <= pending_subindex_in;
         ticks_left_ff       <= ticks_left_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_ff.kind;
   assign rsp_tx_id           = rsp_ff.tx_id;
   assign rsp_payload         = rsp_ff.payload;
   assign rsp_payload_len     = rsp_ff.payload_len;
   assign rsp_node            = rsp_ff.node;
   assign rsp_nmt_state       = rsp_ff.nmt_state;
   assign rsp_pdo_number      = rsp_ff.pdo_number;
   assign rsp_pdo_is_transmit = rsp_ff.pdo_is_transmit;
   assign rsp_success         = rsp_ff.success;
   assign rsp_result_index    = rsp_ff.result_index;
   assign rsp_result_subindex = rsp_ff.result_subindex;
   assign rsp_result_value    = rsp_ff.result_value;

endmodule

`default_nettype wire

// ===== bench/canopen_master_frame_engine_test.sv =====
`default_nettype none

module canopen_master_frame_engine_test;
   import cmfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Mode codes that the block must ignore
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   // Upload answer flag bits: expedited, size indicated
   localparam logic [7:0] SCS_E_BIT = 8'h02;
   localparam logic [7:0] SCS_S_BIT = 8'h01;

   // Register byte addresses
   localparam logic [2:0] ADDR_NODE_ID = {RegNodeId, 2'b00};
   localparam logic [2:0] ADDR_TIMEOUT = {RegTimeout, 2'b00};

   localparam int PHASE_REQUESTS = 135;
   localparam int LONG_HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode = '0;
   logic [15:0] req_obj_index = '0;
   logic [7:0]  req_obj_subindex = '0;
   logic [31:0] req_write_value = '0;
   logic [2:0]  req_write_size = '0;
   logic [7:0]  req_nmt_command = '0;
   logic [6:0]  req_target_node = '0;
   logic [10:0] req_frame_id = '0;
   logic        req_frame_extended = 1'b0;
   logic [3:0]  req_frame_len = '0;
   logic [63:0] req_frame_data = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [10:0] rsp_tx_id;
   logic [63:0] rsp_payload;
   logic [3:0]  rsp_payload_len;
   logic [6:0]  rsp_node;
   logic [2:0]  rsp_nmt_state;
   logic [2:0]  rsp_pdo_number;
   logic        rsp_pdo_is_transmit;
   logic        rsp_success;
   logic [15:0] rsp_result_index;
   logic [7:0]  rsp_result_subindex;
   logic [31:0] rsp_result_value;

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   canopen_master_frame_engine DUT (.*);

   always #5 clock = ~clock;

   // Shadow of the engine: configuration and SDO transfer state
   logic [6:0]  cfg_node_id = NODE_ID_RESET;
   logic [15:0] cfg_timeout = TIMEOUT_RESET;
   logic        sdo_busy = 1'b0;
   logic        busy_is_read = 1'b0;
   logic [15:0] busy_index = '0;
   logic [7:0]  busy_subindex = '0;
   logic [15:0] ticks_remaining = '0;

   req_type     request_queue[$];
   rsp_type     expected_results[$];
   req_type     offered_req;
   int unsigned mismatch_count = 0;
   int          requests_made = 0;

   // Sender and receiver pacing
   int          burst_left = 0;
   int          gap_left = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int          pattern_left = 0;
   int          stall_density = 0;

   function automatic logic [63:0] mask_to_bytes(input logic [63:0] d, input logic [3:0] n);
      if (n >= 4'd8) begin
         return d;
      end
      return d & ((64'd1 << (8 * n)) - 64'd1);
   endfunction

   function automatic void finish_transfer(inout rsp_type o, input logic ok,
                                           input logic [31:0] value);
      o.kind = busy_is_read ? KIND_READ_DONE : KIND_WRITE_DONE;
      o.success = ok;
      o.result_index = busy_index;
      o.result_subindex = busy_subindex;
      o.result_value = value;
   endfunction

   // Decode a response to the pending transfer
   function automatic bit predict_sdo_answer(input logic [63:0] data, input logic [3:0] len,
                                             inout rsp_type o);
      logic [7:0]  scs;
      int          nbytes;
      logic [31:0] value;
      if (!sdo_busy || len == 4'd0) begin
         return 1'b0;
      end
      sdo_busy = 1'b0;
      ticks_remaining = '0;
      scs = data[7:0];
      value = '0;
      if (scs == SDO_SCS_ABORT) begin
         if (len >= 4'd8) begin
            value = data[63:32];
         end
         finish_transfer(o, 1'b0, value);
      end else if (!busy_is_read) begin
         finish_transfer(o, scs == SDO_SCS_DL_ACK, '0);
      end else if ((scs & SDO_SCS_MASK) != SDO_SCS_UPLOAD) begin
         finish_transfer(o, 1'b0, '0);
      end else begin
         nbytes = 4;
         if (scs[1] && scs[0]) begin
            nbytes = 4 - int'(scs[3:2]);
         end
         for (int i = 0; i < 4; i++) begin
            if (i < nbytes && 4 + i < int'(len)) begin
               value[8*i +: 8] = data[8*(4+i) +: 8];
            end
         end
         finish_transfer(o, 1'b1, value);
      end
      return 1'b1;
   endfunction

   // Classify a received standard frame
   function automatic bit predict_rx_frame(input req_type r, inout rsp_type o);
      logic [3:0]  len;
      logic [63:0] data;
      logic [3:0]  fcode;
      logic [6:0]  src;
      if (r.frame_extended) begin
         return 1'b0;
      end
      len = (r.frame_len > 4'd8) ? 4'd8 : r.frame_len;
      data = mask_to_bytes(r.frame_data, len);
      fcode = r.frame_id[10:7];
      src = r.frame_id[6:0];
      if (fcode == FC_HEARTBEAT && src != '0) begin
         o.kind = KIND_HEARTBEAT;
         o.node = src;
         if (len != 4'd0) begin
            case (data[6:0])
               HB_BOOT_UP:     o.nmt_state = NMT_BOOT_UP;
               HB_STOPPED:     o.nmt_state = NMT_STOPPED;
               HB_OPERATIONAL: o.nmt_state = NMT_OPERATIONAL;
               HB_PRE_OP:      o.nmt_state = NMT_PRE_OP;
               default:        o.nmt_state = NMT_UNKNOWN;
            endcase
         end
         return 1'b1;
      end
      if (fcode == FC_EMCY && src != '0) begin
         if (len < 4'd3) begin
            return 1'b0;
         end
         o.kind = KIND_EMCY;
         o.node = src;
         o.result_value = {8'd0, data[23:0]};
         o.payload = data >> 24;
         o.payload_len = len - 4'd3;
         return 1'b1;
      end
      if (fcode == FC_SDO_RESP && src == cfg_node_id) begin
         return predict_sdo_answer(data, len, o);
      end
      if (src == '0) begin
         return 1'b0;
      end
      case (fcode)
         FC_TPDO1, FC_TPDO2, FC_TPDO3, FC_TPDO4,
         FC_RPDO1, FC_RPDO2, FC_RPDO3, FC_RPDO4: begin
            o.kind = KIND_PDO;
            o.node = src;
            // codes alternate TPDOn, RPDOn starting at TPDO1
            o.pdo_number = 3'((fcode - FC_TPDO1) / 2 + 1);
            o.pdo_is_transmit = ((fcode - FC_TPDO1) % 2) == 0;
            o.payload = data;
            o.payload_len = len;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Expected result of one accepted request; returns 0 when none is due
   function automatic bit predict_frame_result(input req_type r, output rsp_type o);
      logic [7:0]  cmd;
      logic [31:0] data_bytes;
      o = '0;
      case (r.mode)
         MODE_SDO_WRITE, MODE_SDO_READ: begin
            if (r.mode == MODE_SDO_WRITE && (r.write_size < 3'd1 || r.write_size > 3'd4)) begin
               return 1'b1;
            end
            if (sdo_busy) begin
               return 1'b1;
            end
            if (r.mode == MODE_SDO_WRITE) begin
               cmd = SDO_CMD_DOWNLOAD | {4'd0, 2'(3'd4 - r.write_size), 2'b00};
               data_bytes = 32'(mask_to_bytes({32'd0, r.write_value}, {1'b0, r.write_size}));
            end else begin
               cmd = SDO_CMD_UPLOAD;
               data_bytes = '0;
            end
            o.kind = KIND_TRANSMIT;
            o.tx_id = ID_SDO_REQ + {4'd0, cfg_node_id};
            o.payload = {data_bytes, r.obj_subindex, r.obj_index, cmd};
            o.payload_len = 4'd8;
            sdo_busy = 1'b1;
            busy_is_read = (r.mode == MODE_SDO_READ);
            busy_index = r.obj_index;
            busy_subindex = r.obj_subindex;
            ticks_remaining = cfg_timeout;
            return 1'b1;
         end
         MODE_RX_FRAME: return predict_rx_frame(r, o);
         MODE_TICK: begin
            if (!sdo_busy) begin
               return 1'b0;
            end
            if (ticks_remaining > 16'd1) begin
               ticks_remaining--;
               return 1'b0;
            end
            ticks_remaining = '0;
            sdo_busy = 1'b0;
            finish_transfer(o, 1'b0, SDO_ABORT_TIMEOUT);
            return 1'b1;
         end
         MODE_NMT: begin
            o.kind = KIND_TRANSMIT;
            o.tx_id = ID_NMT;
            o.payload = {49'd0, r.target_node, r.nmt_command};
            o.payload_len = 4'd2;
            return 1'b1;
         end
         MODE_SYNC: begin
            o.kind = KIND_TRANSMIT;
            o.tx_id = ID_SYNC;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Request builders: fields a mode does not use stay random
   function automatic req_type noise_fill();
      req_type r;
      r.mode = 3'($urandom_range(0, 7));
      r.obj_index = 16'($urandom);
      r.obj_subindex = 8'($urandom);
      r.write_value = $urandom;
      r.write_size = 3'($urandom);
      r.nmt_command = 8'($urandom);
      r.target_node = 7'($urandom);
      r.frame_id = 11'($urandom);
      r.frame_extended = 1'($urandom);
      r.frame_len = 4'($urandom);
      r.frame_data = {$urandom, $urandom};
      return r;
   endfunction

   function automatic req_type make_simple(input mode_type m);
      req_type r;
      r = noise_fill();
      r.mode = m;
      return r;
   endfunction

   function automatic req_type make_nmt(input logic [7:0] cmd, input logic [6:0] target);
      req_type r;
      r = make_simple(MODE_NMT);
      r.nmt_command = cmd;
      r.target_node = target;
      return r;
   endfunction

   function automatic req_type make_sdo_read(input logic [15:0] idx, input logic [7:0] sub);
      req_type r;
      r = make_simple(MODE_SDO_READ);
      r.obj_index = idx;
      r.obj_subindex = sub;
      return r;
   endfunction

   function automatic req_type make_sdo_write(input logic [15:0] idx, input logic [7:0] sub,
                                              input logic [31:0] value, input logic [2:0] size);
      req_type r;
      r = make_simple(MODE_SDO_WRITE);
      r.obj_index = idx;
      r.obj_subindex = sub;
      r.write_value = value;
      r.write_size = size;
      return r;
   endfunction

   function automatic req_type make_frame(input logic [10:0] id, input logic [3:0] len,
                                          input logic [63:0] data);
      req_type r;
      r = make_simple(MODE_RX_FRAME);
      r.frame_id = id;
      r.frame_extended = 1'b0;
      r.frame_len = len;
      r.frame_data = data;
      return r;
   endfunction

   // Mostly legal lengths, now and then an oversized one
   function automatic logic [3:0] rand_len();
      if ($urandom_range(0, 9) == 0) begin
         return 4'($urandom_range(9, 15));
      end
      return 4'($urandom_range(0, 8));
   endfunction

   function automatic logic [6:0] rand_node();
      return 7'($urandom_range(0, 127));
   endfunction

   task automatic push_req(input req_type r);
      request_queue.push_back(r);
      if (r.mode <= MODE_SYNC) begin
         requests_made++;
      end
   endtask

   // Server answer to the transfer just requested
   task automatic queue_sdo_reply(input bit for_read);
      logic [63:0] data;
      logic [3:0]  len;
      int          pick;
      data = {$urandom, $urandom};
      len = 4'd8;
      pick = $urandom_range(0, 9);
      if (for_read) begin
         case (pick)
            0, 1, 2, 3, 4:
               data[7:0] = SDO_SCS_UPLOAD | SCS_E_BIT | SCS_S_BIT | 8'($urandom_range(0, 3) << 2);
            5: data[7:0] = SDO_SCS_UPLOAD | SCS_E_BIT;
            6: data[7:0] = SDO_SCS_UPLOAD | 8'($urandom_range(0, 31));
            7: data[7:0] = SDO_SCS_ABORT;
            default: data[7:0] = 8'($urandom);
         endcase
      end else begin
         case (pick)
            0, 1, 2, 3, 4, 5: data[7:0] = SDO_SCS_DL_ACK;
            6, 7: data[7:0] = SDO_SCS_ABORT;
            default: data[7:0] = 8'($urandom);
         endcase
      end
      if ($urandom_range(0, 5) == 0) begin
         len = rand_len();
      end
      push_req(make_frame({FC_SDO_RESP, cfg_node_id}, len, data));
   endtask

   // Unrelated traffic: network events, other commands and noise
   task automatic queue_side_item();
      req_type     r;
      logic [63:0] data;
      logic [6:0]  state;
      case ($urandom_range(0, 9))
         0, 1: begin
            case ($urandom_range(0, 4))
               0: state = HB_BOOT_UP;
               1: state = HB_STOPPED;
               2: state = HB_OPERATIONAL;
               3: state = HB_PRE_OP;
               default: state = 7'($urandom);
            endcase
            data = {$urandom, $urandom};
            data[7:0] = {1'($urandom), state};
            push_req(make_frame({FC_HEARTBEAT, rand_node()},
                                ($urandom_range(0, 3) == 0) ? rand_len() : 4'd1, data));
         end
         2: push_req(make_frame({FC_EMCY, rand_node()}, rand_len(), {$urandom, $urandom}));
         3, 4: begin
            // PDO function codes are contiguous from TPDO1 to RPDO4
            push_req(make_frame({FC_TPDO1 + 4'($urandom_range(0, 7)), rand_node()},
                                rand_len(), {$urandom, $urandom}));
         end
         5: push_req(make_nmt(8'($urandom), 7'($urandom)));
         6: push_req(make_simple(MODE_SYNC));
         7: push_req(make_simple(MODE_TICK));
         8: begin
            r = noise_fill();
            r.mode = ($urandom_range(0, 1) == 0) ? MODE_SDO_READ : MODE_SDO_WRITE;
            push_req(r);
         end
         default: push_req(noise_fill());
      endcase
   endtask

   // Request, some unrelated traffic, then an answer or a run of ticks to timeout
   task automatic queue_sdo_exchange();
      bit for_read;
      int extra;
      for_read = 1'($urandom_range(0, 1));
      if (for_read) begin
         push_req(make_sdo_read(16'($urandom), 8'($urandom)));
      end else begin
         push_req(make_sdo_write(16'($urandom), 8'($urandom), $urandom,
                                 3'($urandom_range(1, 4))));
      end
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (extra) queue_side_item();
      if (cfg_timeout <= 16'd8 && $urandom_range(0, 2) == 0) begin
         repeat ((cfg_timeout == 16'd0) ? 1 : int'(cfg_timeout)) push_req(make_simple(MODE_TICK));
      end else begin
         queue_sdo_reply(for_read);
      end
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_config(input logic [6:0] node, input logic [15:0] timeout);
      csr_write(ADDR_NODE_ID, {25'd0, node});
      cfg_node_id = node;
      csr_write(ADDR_TIMEOUT, {16'd0, timeout});
      cfg_timeout = timeout;
   endtask

   // Sender holds off until all requests are taken and all results are back
   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (request_queue.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic check_field(input string fname, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
      end
   endtask

   // Request driver: bursts with random gaps, payload held while stalled
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_stall === 1'b0) begin
            if (predict_frame_result(offered_req, exp_rsp)) begin
               expected_results.push_back(exp_rsp);
            end
         end
         if (!(req_valid && req_stall !== 1'b0)) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               offered_req = request_queue.pop_front();
               req_mode <= offered_req.mode;
               req_obj_index <= offered_req.obj_index;
               req_obj_subindex <= offered_req.obj_subindex;
               req_write_value <= offered_req.write_value;
               req_write_size <= offered_req.write_size;
               req_nmt_command <= offered_req.nmt_command;
               req_target_node <= offered_req.target_node;
               req_frame_id <= offered_req.frame_id;
               req_frame_extended <= offered_req.frame_extended;
               req_frame_len <= offered_req.frame_len;
               req_frame_data <= offered_req.frame_data;
               req_valid <= 1'b1;
               if (burst_left != 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result stall: density redrawn at random intervals, plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(16, 80);
            stall_density = $urandom_range(0, 6);
         end else begin
            pattern_left--;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 7) < stall_density);
         end
      end
   end

   // Result checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected result: expected none, actual kind %0d", $time, rsp_kind);
         end else begin
            want = expected_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("tx_id", want.tx_id, rsp_tx_id);
            check_field("payload", want.payload, rsp_payload);
            check_field("payload_len", want.payload_len, rsp_payload_len);
            check_field("node", want.node, rsp_node);
            check_field("nmt_state", want.nmt_state, rsp_nmt_state);
            check_field("pdo_number", want.pdo_number, rsp_pdo_number);
            check_field("pdo_is_transmit", want.pdo_is_transmit, rsp_pdo_is_transmit);
            check_field("success", want.success, rsp_success);
            check_field("result_index", want.result_index, rsp_result_index);
            check_field("result_subindex", want.result_subindex, rsp_result_subindex);
            check_field("result_value", want.result_value, rsp_result_value);
         end
      end
   end

   // Stimulus sequence
   initial begin
      req_type    r;
      logic [6:0] phase_node[6];
      logic [15:0] phase_timeout[6];
      phase_node = '{NODE_ID_RESET, 7'd127, 7'd0, 7'h55, 7'd127, 7'($urandom)};
      phase_timeout = '{TIMEOUT_RESET, 16'd0, 16'd1, 16'd3, 16'hFFFF,
                        16'($urandom_range(1, 6))};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed requests at reset configuration
      push_req(make_simple(MODE_SYNC));
      push_req(make_nmt(8'hFF, 7'h7F));
      push_req(make_nmt(8'h00, 7'h00));
      push_req(make_sdo_write(16'h1000, 8'h01, 32'h1234_5678, 3'd0));
      push_req(make_sdo_write(16'h1000, 8'h01, 32'h1234_5678, 3'd7));
      r = noise_fill();
      r.mode = MODE_SPARE_A;
      push_req(r);
      r.mode = MODE_SPARE_B;
      push_req(r);
      push_req(make_simple(MODE_TICK));
      // write of one byte at the top index, then a read while it is pending
      push_req(make_sdo_write(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 3'd1));
      push_req(make_sdo_read(16'h2000, 8'h00));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd8, {56'd0, SDO_SCS_DL_ACK}));
      // empty answer is dropped, the next one carries one byte
      push_req(make_sdo_read(16'h0000, 8'h00));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd0, 64'h0000_0000_0000_0043));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd8, 64'hDDCC_BBAA_0000_004F));
      // abort too short to carry a code
      push_req(make_sdo_read(16'h1018, 8'h01));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd5, 64'h0504_0001_0018_1880));
      push_req(make_sdo_write(16'h6040, 8'h00, 32'hCAFE_F00D, 3'd4));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd8, 64'h0800_0000_0060_4080));
      // unsized upload answer cut at six bytes, then an answer of the wrong kind
      push_req(make_sdo_read(16'h1008, 8'h00));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd6, 64'hFFFF_4433_0010_0842));
      push_req(make_sdo_read(16'h1009, 8'h00));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd8, 64'h0000_0000_0000_0020));
      push_req(make_frame({FC_SDO_RESP, 7'd1}, 4'd8, {56'd0, SDO_SCS_DL_ACK}));
      push_req(make_frame({FC_HEARTBEAT, 7'h7F}, 4'd1, 64'h05));
      push_req(make_frame({FC_HEARTBEAT, 7'h03}, 4'd0, 64'h05));
      push_req(make_frame({FC_HEARTBEAT, 7'h09}, 4'd1, 64'hFF));
      push_req(make_frame({FC_HEARTBEAT, 7'h00}, 4'd1, 64'h05));
      push_req(make_frame({FC_EMCY, 7'h02}, 4'd2, 64'hFFFF));
      push_req(make_frame({FC_EMCY, 7'h7F}, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
      push_req(make_frame({FC_TPDO1, 7'h01}, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
      push_req(make_frame({FC_RPDO4, 7'h05}, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF));
      r = make_frame({FC_TPDO2, 7'h10}, 4'd8, 64'h1);
      r.frame_extended = 1'b1;
      push_req(r);
      wait_drained();

      // Random phases, each under its own configuration
      for (int phase = 0; phase < 6; phase++) begin
         // results may still be in flight behind requests that produce none
         repeat (4) @(negedge clock);
         set_config(phase_node[phase], phase_timeout[phase]);
         requests_made = 0;
         while (requests_made < PHASE_REQUESTS) begin
            if ($urandom_range(0, 99) < 50) begin
               queue_sdo_exchange();
            end else begin
               queue_side_item();
            end
         end
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("[canopen_master_frame_engine] OK");
      end else begin
         $display("[canopen_master_frame_engine] ERROR");
      end
      $finish;
   end

   // Run limit
   initial begin
      #3_000_000;
      $display("[canopen_master_frame_engine] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
